[rtl/wpa_pkg.sv]
// wpa_pkg: shared types and codes of the worker pool allocator
// command and status codes, payload word types, control state type
// no dependencies
`default_nettype none

package wpa_pkg;

    localparam int PROC_W   = 4;
    localparam int THREAD_W = 6;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 5;

    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALL     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NAMED   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PROC = 2'd2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [PROC_W-1:0]   process_id;
        logic [THREAD_W-1:0] thread_id;
        logic [COUNT_W-1:0]  count;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_pair;
        logic [PROC_W-1:0]   process_out;
        logic [THREAD_W-1:0] thread_out;
        logic                last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_TAKE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

[rtl/worker_pool_allocator_core.sv]
// worker_pool_allocator_core: pool of free worker thread ids with owning processes
// owner memory with registered read, free flags in flops, scan sequencer
// depends on wpa_pkg
//
// Usage: commands arrive on in_valid/in_ready as in_word_t; results leave on
// out_valid/out_ready as out_word_t, one word per granted thread or a single
// status word otherwise, the final word of each command marked with last.
// cfg_write_en/cfg_write_data set the number of active processes; the user
// writes them only while the block is idle; the block does not enforce this.
// One command is handled at a time; in_ready is high only when idle.
// A release or any command answered without scanning goes through ST_RESP
// to the output register. An allocation scans the owner memory once to
// count free threads per process, decides in ST_DECIDE, then makes one scan
// per granted process, ending early once count threads are found; the
// all-process command makes one scan for each active process. The owner
// memory's single read port sets the pace: one thread id per cycle.
// When the receiver stalls, the scan holds on the pending thread and resumes
// when the output register frees. Reset empties the pool (free flags cleared),
// sets the active process count to 16 and returns to idle; no clearing pass.
`default_nettype none

module worker_pool_allocator_core #(
    parameter int THREAD_IDS = 64,
    parameter int PROCESSES  = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wpa_pkg::in_word_t                  in_word,
    output logic                               out_valid,
    input  wire                                out_ready,
    output wpa_pkg::out_word_t                 out_word,
    input  wire                                cfg_write_en,
    input  wire  [wpa_pkg::ACTIVE_W-1:0]       cfg_write_data
);

    localparam int IW = (THREAD_IDS > 1) ? $clog2(THREAD_IDS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(THREAD_IDS - 1);

    // owner memory
    logic [wpa_pkg::PROC_W-1:0] owner_mem [THREAD_IDS];

    wpa_pkg::state_t state_reg, state_next;

    logic [THREAD_IDS-1:0]           free_reg;
    logic [wpa_pkg::ACTIVE_W-1:0]    active_reg;
    logic [wpa_pkg::CMD_W-1:0]       cmd_reg;
    logic [wpa_pkg::PROC_W-1:0]      pid_reg;
    logic [wpa_pkg::COUNT_W-1:0]     cnt_reg;
    logic [wpa_pkg::STATUS_W-1:0]    resp_status_reg;
    logic [wpa_pkg::STATUS_W-1:0]    resp_status_next;
    logic [IW-1:0]                   ptr_reg;
    logic                            issuing_reg;
    logic                            dvalid_reg;
    logic [IW-1:0]                   didx_reg;
    logic [wpa_pkg::PROC_W-1:0]      rdata_reg;
    logic [wpa_pkg::COUNT_W-1:0]     got_reg;
    logic [wpa_pkg::PROC_W-1:0]      cur_proc_reg;
    logic [wpa_pkg::PROC_W-1:0]      last_proc_reg;
    logic [wpa_pkg::COUNT_W-1:0]     proc_cnt_reg [PROCESSES];
    logic                            out_valid_reg;
    wpa_pkg::out_word_t              out_word_reg;

    logic                            accept;
    logic                            pid_ok;
    logic                            tid_ok;
    logic                            quick;
    logic [wpa_pkg::ACTIVE_W-1:0]    np;
    logic                            out_free;
    logic                            d_match;
    logic                            emit;
    logic                            stall;
    logic                            pass_done;
    logic                            take_end;
    logic                            count_end;
    logic                            scanning;
    logic                            rd_en;
    logic [PROCESSES-1:0]            enough;
    logic                            grant_ok;
    logic [wpa_pkg::PROC_W-1:0]      grant_first;
    logic [wpa_pkg::PROC_W-1:0]      grant_last;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign accept   = in_valid && in_ready;
    assign pid_ok   = 32'(in_word.process_id) < PROCESSES;
    assign tid_ok   = 32'(in_word.thread_id) < THREAD_IDS;
    assign np       = (32'(active_reg) > PROCESSES) ? wpa_pkg::ACTIVE_W'(PROCESSES) : active_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign d_match   = dvalid_reg && free_reg[didx_reg] && (rdata_reg == cur_proc_reg);
    assign emit      = (state_reg == wpa_pkg::ST_TAKE) && d_match;
    assign stall     = emit && !out_free;
    assign pass_done = emit && out_free && ((got_reg + 1'b1) == cnt_reg);
    assign take_end  = pass_done && (cur_proc_reg == last_proc_reg);
    assign count_end = (state_reg == wpa_pkg::ST_COUNT) && dvalid_reg && (didx_reg == LAST_IDX);

    always_comb
    begin
        quick = 1'b0;
        resp_status_next = wpa_pkg::STATUS_GRANTED;
        if ((in_word.command == wpa_pkg::CMD_RELEASE || in_word.command == wpa_pkg::CMD_NAMED)
            && !pid_ok)
        begin
            quick = 1'b1;
            resp_status_next = wpa_pkg::STATUS_BAD_PROC;
        end
        else if (in_word.command == wpa_pkg::CMD_RELEASE || in_word.count == '0
                 || (in_word.command == wpa_pkg::CMD_ALL && np == '0))
        begin
            quick = 1'b1;
        end
    end

    // grant decision over the per-process counts
    always_comb
    begin
        grant_ok    = 1'b0;
        grant_first = '0;
        grant_last  = '0;
        for (int p = 0; p < PROCESSES; p++)
        begin
            enough[p] = proc_cnt_reg[p] >= cnt_reg;
        end
        unique case (cmd_reg)
            wpa_pkg::CMD_ALL:
            begin
                grant_ok   = 1'b1;
                grant_last = wpa_pkg::PROC_W'(np - 1'b1);
                for (int p = 0; p < PROCESSES; p++)
                begin
                    if (32'(np) > p && !enough[p])
                    begin
                        grant_ok = 1'b0;
                    end
                end
            end
            wpa_pkg::CMD_FIRST:
            begin
                for (int p = PROCESSES - 1; p >= 0; p--)
                begin
                    if (enough[p])
                    begin
                        grant_ok    = 1'b1;
                        grant_first = wpa_pkg::PROC_W'(p);
                        grant_last  = wpa_pkg::PROC_W'(p);
                    end
                end
            end
            wpa_pkg::CMD_NAMED:
            begin
                grant_ok    = enough[pid_reg];
                grant_first = pid_reg;
                grant_last  = pid_reg;
            end
            default:
            begin
                grant_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = quick ? wpa_pkg::ST_RESP : wpa_pkg::ST_COUNT;
                end
            end
            wpa_pkg::ST_COUNT:
            begin
                if (count_end)
                begin
                    state_next = wpa_pkg::ST_DECIDE;
                end
            end
            wpa_pkg::ST_DECIDE:
            begin
                state_next = grant_ok ? wpa_pkg::ST_TAKE : wpa_pkg::ST_RESP;
            end
            wpa_pkg::ST_TAKE:
            begin
                if (take_end)
                begin
                    state_next = wpa_pkg::ST_IDLE;
                end
            end
            wpa_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = wpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpa_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = (state_reg == wpa_pkg::ST_IDLE);
        scanning = (state_reg == wpa_pkg::ST_COUNT) || (state_reg == wpa_pkg::ST_TAKE);
        rd_en    = scanning && issuing_reg && !stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= wpa_pkg::ACTIVE_RESET;
        end
        else if (cfg_write_en)
        begin
            active_reg <= cfg_write_data;
        end
    end

    // owner memory write and read
    always_ff @(posedge clk)
    begin
        if (accept && in_word.command == wpa_pkg::CMD_RELEASE && pid_ok && tid_ok)
        begin
            owner_mem[in_word.thread_id[IW-1:0]] <= in_word.process_id;
        end
        if (rd_en)
        begin
            rdata_reg <= owner_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
        end
        else if (accept && in_word.command == wpa_pkg::CMD_RELEASE && pid_ok && tid_ok)
        begin
            free_reg[in_word.thread_id[IW-1:0]] <= 1'b1;
        end
        else if (emit && out_free)
        begin
            free_reg[didx_reg] <= 1'b0;
        end
    end

    // scan sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            dvalid_reg  <= 1'b0;
        end
        else if ((accept && !quick) || (state_reg == wpa_pkg::ST_DECIDE && grant_ok)
                 || (pass_done && !take_end))
        begin
            issuing_reg <= 1'b1;
            dvalid_reg  <= 1'b0;
        end
        else if (scanning && !stall)
        begin
            dvalid_reg <= issuing_reg;
            if (issuing_reg && ptr_reg == LAST_IDX)
            begin
                issuing_reg <= 1'b0;
            end
        end
        else if (!scanning)
        begin
            issuing_reg <= 1'b0;
            dvalid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((accept && !quick) || (state_reg == wpa_pkg::ST_DECIDE && grant_ok)
            || (pass_done && !take_end))
        begin
            ptr_reg <= '0;
        end
        else if (rd_en)
        begin
            didx_reg <= ptr_reg;
            if (ptr_reg != LAST_IDX)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // command latch and take progress
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= in_word.command;
            pid_reg         <= in_word.process_id;
            cnt_reg         <= in_word.count;
            resp_status_reg <= resp_status_next;
        end
        else if (state_reg == wpa_pkg::ST_DECIDE)
        begin
            cur_proc_reg    <= grant_first;
            last_proc_reg   <= grant_last;
            got_reg         <= '0;
            resp_status_reg <= wpa_pkg::STATUS_REFUSED;
        end
        else if (pass_done)
        begin
            cur_proc_reg <= cur_proc_reg + 1'b1;
            got_reg      <= '0;
        end
        else if (emit && out_free)
        begin
            got_reg <= got_reg + 1'b1;
        end
    end

    // per-process free counts
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < PROCESSES; p++)
        begin
            if (accept)
            begin
                proc_cnt_reg[p] <= '0;
            end
            else if (state_reg == wpa_pkg::ST_COUNT && dvalid_reg && free_reg[didx_reg]
                     && rdata_reg == wpa_pkg::PROC_W'(p))
            begin
                proc_cnt_reg[p] <= proc_cnt_reg[p] + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == wpa_pkg::ST_RESP || emit) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == wpa_pkg::ST_RESP && out_free)
        begin
            out_word_reg.status      <= resp_status_reg;
            out_word_reg.has_pair    <= 1'b0;
            out_word_reg.process_out <= '0;
            out_word_reg.thread_out  <= '0;
            out_word_reg.last        <= 1'b1;
        end
        else if (emit && out_free)
        begin
            out_word_reg.status      <= wpa_pkg::STATUS_GRANTED;
            out_word_reg.has_pair    <= 1'b1;
            out_word_reg.process_out <= cur_proc_reg;
            out_word_reg.thread_out  <= wpa_pkg::THREAD_W'(didx_reg);
            out_word_reg.last        <= take_end;
        end
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench: self-checking bench for worker_pool_allocator_core
// grant tracker class predicts result words; tasks drive commands and register writes
// depends on wpa_pkg and rtl/worker_pool_allocator_core.sv
`timescale 1ns / 100ps

module testbench;

    localparam int THREAD_COUNT  = 64;
    localparam int PROCESS_COUNT = 16;
    localparam int PHASE_COUNT   = 7;
    localparam int RANDOM_PER_PHASE = 33;
    localparam int CYCLE_LIMIT   = 2000000;

    class grant_tracker;
        bit                           free_map[THREAD_COUNT];
        logic [wpa_pkg::PROC_W-1:0]   owner_of[THREAD_COUNT];
        int unsigned                  active_cnt;
        wpa_pkg::out_word_t           pending[$];
        int unsigned                  errors;
        int unsigned                  words_checked;
        int unsigned                  commands;
        int unsigned                  grants;
        int unsigned                  refusals;

        function new();
            foreach (free_map[t])
            begin
                free_map[t] = 1'b0;
                owner_of[t] = '0;
            end
            active_cnt = 32'(wpa_pkg::ACTIVE_RESET);
            errors = 0;
            words_checked = 0;
            commands = 0;
            grants = 0;
            refusals = 0;
        endfunction

        task report(input string msg);
            if (errors < 50)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function int unsigned free_count(input int unsigned p);
            int unsigned n;
            n = 0;
            for (int t = 0; t < THREAD_COUNT; t++)
                if (free_map[t] && owner_of[t] == p)
                    n++;
            return n;
        endfunction

        function void push_plain(input logic [wpa_pkg::STATUS_W-1:0] status);
            wpa_pkg::out_word_t e;
            e = '0;
            e.status = status;
            e.last = 1'b1;
            pending.insert(pending.size(), e);
            if (status == wpa_pkg::STATUS_REFUSED)
                refusals++;
        endfunction

        function void take_threads(input int unsigned p, input int unsigned n);
            wpa_pkg::out_word_t e;
            int unsigned        got;
            got = 0;
            for (int t = 0; t < THREAD_COUNT && got < n; t++)
            begin
                if (free_map[t] && owner_of[t] == p)
                begin
                    free_map[t] = 1'b0;
                    e = '0;
                    e.status = wpa_pkg::STATUS_GRANTED;
                    e.has_pair = 1'b1;
                    e.process_out = wpa_pkg::PROC_W'(p);
                    e.thread_out = wpa_pkg::THREAD_W'(t);
                    pending.insert(pending.size(), e);
                    got++;
                    grants++;
                end
            end
        endfunction

        function void note_command(input wpa_pkg::in_word_t w);
            int unsigned np;
            int unsigned cnt;
            int unsigned start_size;
            bit          found;
            commands++;
            cnt = 32'(w.count);
            start_size = pending.size();
            unique case (w.command)
                wpa_pkg::CMD_RELEASE:
                begin
                    if (w.process_id >= PROCESS_COUNT)
                        push_plain(wpa_pkg::STATUS_BAD_PROC);
                    else
                    begin
                        free_map[w.thread_id] = 1'b1;
                        owner_of[w.thread_id] = w.process_id;
                        push_plain(wpa_pkg::STATUS_GRANTED);
                    end
                    return;
                end
                wpa_pkg::CMD_ALL:
                begin
                    np = (active_cnt > PROCESS_COUNT) ? PROCESS_COUNT : active_cnt;
                    for (int unsigned p = 0; p < np; p++)
                    begin
                        if (free_count(p) < cnt)
                        begin
                            push_plain(wpa_pkg::STATUS_REFUSED);
                            return;
                        end
                    end
                    if (cnt != 0)
                        for (int unsigned p = 0; p < np; p++)
                            take_threads(p, cnt);
                end
                wpa_pkg::CMD_FIRST:
                begin
                    if (cnt != 0)
                    begin
                        found = 1'b0;
                        for (int unsigned p = 0; p < PROCESS_COUNT && !found; p++)
                        begin
                            if (free_count(p) >= cnt)
                            begin
                                take_threads(p, cnt);
                                found = 1'b1;
                            end
                        end
                        if (!found)
                        begin
                            push_plain(wpa_pkg::STATUS_REFUSED);
                            return;
                        end
                    end
                end
                default:
                begin
                    if (w.process_id >= PROCESS_COUNT)
                    begin
                        push_plain(wpa_pkg::STATUS_BAD_PROC);
                        return;
                    end
                    if (cnt != 0)
                    begin
                        if (free_count(32'(w.process_id)) < cnt)
                        begin
                            push_plain(wpa_pkg::STATUS_REFUSED);
                            return;
                        end
                        take_threads(32'(w.process_id), cnt);
                    end
                end
            endcase
            if (pending.size() == start_size)
                push_plain(wpa_pkg::STATUS_GRANTED);
            else
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        task check_grant(input wpa_pkg::out_word_t got);
            wpa_pkg::out_word_t exp;
            bit                 bad;
            words_checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word st=%0d pair=%0d p=%0d t=%0d last=%0d",
                    got.status, got.has_pair, got.process_out, got.thread_out, got.last));
                return;
            end
            exp = pending.pop_front();
            bad = 1'b0;
            if (got.status !== exp.status)
                bad = 1'b1;
            if (got.has_pair !== exp.has_pair)
                bad = 1'b1;
            if (got.process_out !== exp.process_out)
                bad = 1'b1;
            if (got.thread_out !== exp.thread_out)
                bad = 1'b1;
            if (got.last !== exp.last)
                bad = 1'b1;
            if (bad)
                report($sformatf("st %0d/%0d pair %0d/%0d p %0d/%0d t %0d/%0d last %0d/%0d",
                    got.status, exp.status, got.has_pair, exp.has_pair,
                    got.process_out, exp.process_out, got.thread_out, exp.thread_out,
                    got.last, exp.last));
        endtask

        task finish_check();
            if (pending.size() != 0)
                report($sformatf("%0d expected words never arrived", pending.size()));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    wpa_pkg::in_word_t              in_word = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    wpa_pkg::out_word_t             out_word;
    logic                           cfg_write_en = 1'b0;
    logic [wpa_pkg::ACTIVE_W-1:0]   cfg_write_data = '0;

    grant_tracker          sb = new();
    int unsigned           cycle_count = 0;
    int unsigned           active_setting = 32'(wpa_pkg::ACTIVE_RESET);
    int unsigned           ready_mode = 0;
    int unsigned           run_left = 0;

    worker_pool_allocator_core #(
        .THREAD_IDS(THREAD_COUNT),
        .PROCESSES(PROCESS_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL worker_pool_allocator_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_command(in_word);
            if (out_valid && out_ready)
                sb.check_grant(out_word);
        end
    end

    // receiver stall pattern in randomly chosen modes
    always @(posedge clk)
    begin
        if (cycle_count % 256 == 0)
            ready_mode <= $urandom_range(0, 3);
        if (run_left == 0)
        begin
            unique case (ready_mode)
                0:
                begin
                    out_ready <= 1'b1;
                    run_left <= 16;
                end
                1:
                begin
                    out_ready <= ($urandom_range(0, 1) != 0);
                    run_left <= $urandom_range(1, 3);
                end
                2:
                begin
                    out_ready <= ~out_ready;
                    run_left <= $urandom_range(1, 2);
                end
                default:
                begin
                    out_ready <= ($urandom_range(0, 2) != 0);
                    run_left <= $urandom_range(1, 12);
                end
            endcase
        end
        else
            run_left <= run_left - 1;
    end

    function automatic wpa_pkg::in_word_t make_word(input logic [wpa_pkg::CMD_W-1:0] cmd,
                                                    input int unsigned pid,
                                                    input int unsigned tid,
                                                    input int unsigned cnt);
        wpa_pkg::in_word_t w;
        w.command = cmd;
        w.process_id = wpa_pkg::PROC_W'(pid);
        w.thread_id = wpa_pkg::THREAD_W'(tid);
        w.count = wpa_pkg::COUNT_W'(cnt);
        return w;
    endfunction

    function automatic wpa_pkg::in_word_t random_word();
        int unsigned       r;
        int unsigned       lim;
        int unsigned       q;
        wpa_pkg::in_word_t w;
        r = $urandom_range(0, 99);
        if (r < 50)
            w.command = wpa_pkg::CMD_RELEASE;
        else if (r < 67)
            w.command = wpa_pkg::CMD_ALL;
        else if (r < 84)
            w.command = wpa_pkg::CMD_FIRST;
        else
            w.command = wpa_pkg::CMD_NAMED;
        lim = (active_setting == 0) ? 1 :
              (active_setting > PROCESS_COUNT) ? PROCESS_COUNT : active_setting;
        if ($urandom_range(0, 3) == 0)
            w.process_id = wpa_pkg::PROC_W'($urandom_range(0, PROCESS_COUNT - 1));
        else
            w.process_id = wpa_pkg::PROC_W'($urandom_range(0, lim - 1));
        w.thread_id = wpa_pkg::THREAD_W'($urandom_range(0, THREAD_COUNT - 1));
        q = $urandom_range(0, 19);
        if (q == 0)
            w.count = wpa_pkg::COUNT_W'($urandom_range(0, 127));
        else if (q < 3)
            w.count = '0;
        else
            w.count = wpa_pkg::COUNT_W'($urandom_range(1, 3));
        return w;
    endfunction

    task automatic send_word(input wpa_pkg::in_word_t w);
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 8);
            while (burst != 0 && sent < n)
            begin
                send_word(random_word());
                sent++;
                burst--;
            end
            if (sent < n && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending.size() != 0 || !in_ready)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_active(input int unsigned v);
        cfg_write_en <= 1'b1;
        cfg_write_data <= wpa_pkg::ACTIVE_W'(v);
        active_setting = v;
        sb.active_cnt = v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned settings[PHASE_COUNT];
        settings = '{16, 1, 31, 0, 4, 17, 16};
        settings[PHASE_COUNT-1] = $urandom_range(1, 16);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            write_active(settings[ph]);
            if (ph == 0)
            begin
                // extremes, owner overwrite, zero-size grants, refusals, first fit
                send_word(make_word(wpa_pkg::CMD_RELEASE, 0, 0, 0));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 15, 63, 127));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 3, 10, 5));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 3, 11, 64));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 5, 10, 1));
                send_word(make_word(wpa_pkg::CMD_ALL, 15, 63, 0));
                send_word(make_word(wpa_pkg::CMD_FIRST, 0, 0, 0));
                send_word(make_word(wpa_pkg::CMD_NAMED, 3, 42, 0));
                send_word(make_word(wpa_pkg::CMD_ALL, 0, 0, 1));
                send_word(make_word(wpa_pkg::CMD_NAMED, 3, 0, 127));
                send_word(make_word(wpa_pkg::CMD_NAMED, 15, 0, 64));
                send_word(make_word(wpa_pkg::CMD_FIRST, 9, 21, 1));
                send_word(make_word(wpa_pkg::CMD_FIRST, 0, 0, 2));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 3, 42, 0));
                send_word(make_word(wpa_pkg::CMD_FIRST, 6, 33, 2));
                send_word(make_word(wpa_pkg::CMD_NAMED, 15, 63, 1));
                send_word(make_word(wpa_pkg::CMD_NAMED, 5, 0, 1));
                send_word(make_word(wpa_pkg::CMD_FIRST, 0, 0, 127));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 0, 1, 0));
                send_word(make_word(wpa_pkg::CMD_RELEASE, 0, 1, 0));
                send_word(make_word(wpa_pkg::CMD_NAMED, 0, 0, 1));
            end
            run_random(RANDOM_PER_PHASE);
        end
        wait_idle();
        repeat (20) @(posedge clk);
        sb.finish_check();
        $display("covered %0d commands over %0d register settings: %0d threads granted,",
            sb.commands, PHASE_COUNT, sb.grants);
        $display("%0d refusals, %0d result words checked, %0d mismatches",
            sb.refusals, sb.words_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS worker_pool_allocator_core");
        else
            $display("FAIL worker_pool_allocator_core");
        $finish;
    end

endmodule
